// ===== design/u8tok_pkg.sv =====
// shared constants, types and utf-8 helper functions of the code point tokenizer
// no dependencies
`timescale 1ns / 1ps
package u8tok_pkg;

   localparam int VOCAB_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(VOCAB_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int CP_W        = 21;
   localparam int ID_W        = 10;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 24;
   localparam int RSP_USER_W  = 2;

   localparam logic [ID_W-1:0]  ID_BOS   = ID_W'(1);
   localparam logic [ID_W-1:0]  ID_EOS   = ID_W'(2);
   localparam logic [ID_W-1:0]  ID_UNK   = ID_W'(3);
   localparam logic [CNT_W-1:0] FIRST_ID = CNT_W'(4);
   localparam logic [ID_W-1:0]  ADD_MAX  = {ID_W{1'b1}};

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_EOT  = 1'b1;

   localparam logic CSR_LOWER = 1'b0;
   localparam logic CSR_LEARN = 1'b1;

   localparam logic [2:0] LEN_BAD  = 3'd0;
   localparam logic [2:0] LEN_ONE  = 3'd1;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   typedef struct packed {
      logic accept;
      logic emit_bos;
      logic load;
      logic load_sel;
      logic apply;
      logic final_emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic scan_busy;
      logic bos;
      logic cpa_vld;
      logic cpb_vld;
      logic eot;
   } status_type;

   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] len;
      if (b[7] == 1'b0)            len = LEN_ONE;
      else if (b[7:5] == 3'b110)   len = LEN_TWO;
      else if (b[7:4] == 4'b1110)  len = LEN_THREE;
      else if (b[7:3] == 5'b11110) len = LEN_FOUR;
      else                         len = LEN_BAD;
      return len;
   endfunction

   function automatic logic [CP_W-1:0] norm_cp(input logic [CP_W-1:0] cp,
                                               input logic lower);
      logic [CP_W-1:0] c;
      c = cp;
      if (c == CP_W'(32'h2018) || c == CP_W'(32'h2019)) c = CP_W'(32'h27);
      if (lower && c >= CP_W'(32'h41) && c <= CP_W'(32'h5A)) c = c + CP_W'(32'h20);
      return c;
   endfunction

   function automatic logic [CP_W-1:0] dec2(input logic [7:0] b0, input logic [7:0] b1);
      return CP_W'({b0[4:0], b1[5:0]});
   endfunction

endpackage

// ===== design/u8tok_ram.sv =====
// generic single write, single read memory with registered read data
// no dependencies
`timescale 1ns / 1ps
module u8tok_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/u8tok_ctrl.sv =====
// controller: sequences bos, code point lookups and the end of text result
// depends on u8tok_pkg
`timescale 1ns / 1ps
module u8tok_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  u8tok_pkg::status_type sts,
   output u8tok_pkg::cmd_type    cmd
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_BOS, ST_LOAD, ST_SCAN, ST_APPLY, ST_FINAL
   } state_type;

   state_type state_ff, state_in;
   logic      sel_ff, sel_in;
   logic      ready_ff;
   state_type after_bos, after_cp;

   always_comb begin
      after_bos = sts.cpa_vld ? ST_LOAD : (sts.eot ? ST_FINAL : ST_IDLE);
      after_cp  = (!sel_ff && sts.cpb_vld) ? ST_LOAD : (sts.eot ? ST_FINAL : ST_IDLE);
      cmd = '0;
      cmd.accept   = ready_ff && req_tvalid;
      cmd.load_sel = sel_ff;
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            sel_in = 1'b0;
            if (cmd.accept) state_in = ST_BOS;
         end
         ST_BOS: begin
            if (!sts.bos) state_in = after_bos;
            else if (sts.out_free) begin
               cmd.emit_bos = 1'b1;
               state_in = after_bos;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!sts.scan_busy) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (sts.out_free) begin
               cmd.apply = 1'b1;
               state_in = after_cp;
               sel_in = 1'b1;
            end
         end
         ST_FINAL: begin
            if (sts.out_free) begin
               cmd.final_emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         ready_ff <= (state_in == ST_IDLE) && !cmd.accept;
      end
   end

   assign req_tready = ready_ff;
endmodule

// ===== design/u8tok_dp.sv =====
// datapath: utf-8 assembly, vocabulary table scan, learning and result register
// depends on u8tok_pkg and u8tok_ram
`timescale 1ns / 1ps
module u8tok_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tuser,
   input  logic [u8tok_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [u8tok_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [u8tok_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic                                csr_wdata,
   input  u8tok_pkg::cmd_type                  cmd,
   output u8tok_pkg::status_type               sts
);
   localparam int AW = u8tok_pkg::ADDR_W;
   localparam int CW = u8tok_pkg::CNT_W;
   localparam int PW = u8tok_pkg::CP_W;
   localparam int IW = u8tok_pkg::ID_W;

   logic lower_ff, learn_ff, learn_cfg_ff;
   logic [7:0] p0_ff, p1_ff, p2_ff;
   logic [1:0] cnt_ff;
   logic in_text_ff;
   logic [IW-1:0] added_ff;
   logic full_ff;
   logic [CW-1:0] entries_ff;
   logic bos_ff, eot_ff, cpa_vld_ff, cpb_vld_ff;
   logic [PW-1:0] cpa_ff, cpb_ff, cp_ff;
   logic scan_busy_ff, chk_vld_ff, found_vld_ff;
   logic [CW-1:0] idx_ff;
   logic [AW-1:0] chk_addr_ff, found_ff;
   logic out_vld_ff, out_last_ff, out_sum_ff, out_full_ff;
   logic [IW-1:0] out_id_ff, out_add_ff;

   logic [7:0] b;
   logic [2:0] len_b, need, len1, len2;
   logic cpa_vld_in, cpb_vld_in, bos_in, lower_now, learn_now;
   logic [PW-1:0] cpa_raw, cpb_raw;
   logic c0, c01, c1;
   logic rd_en, match, out_free, out_load, insert;
   logic [PW-1:0] rd_data;

   assign b = req_tdata;
   assign len_b = u8tok_pkg::seq_len(b);
   assign need  = u8tok_pkg::seq_len(p0_ff);
   assign len1  = u8tok_pkg::seq_len(p1_ff);
   assign len2  = u8tok_pkg::seq_len(p2_ff);
   assign lower_now = lower_ff;
   assign learn_now = learn_cfg_ff;

   // decode at acceptance
   always_comb begin
      c0  = (cnt_ff >= 2'd2) && (len1 == u8tok_pkg::LEN_ONE);
      c01 = (cnt_ff == 2'd3) && (len1 == u8tok_pkg::LEN_TWO);
      c1  = (cnt_ff == 2'd3) && (len1 != u8tok_pkg::LEN_TWO) &&
            (len2 == u8tok_pkg::LEN_ONE);
      cpa_raw = '0;
      cpb_raw = PW'(p2_ff);
      cpa_vld_in = 1'b0;
      cpb_vld_in = 1'b0;
      bos_in = !learn_now && !in_text_ff;
      if (req_tuser == u8tok_pkg::FUNC_BYTE) begin
         if (cnt_ff == 2'd0) begin
            cpa_raw = PW'(b);
            cpa_vld_in = (len_b == u8tok_pkg::LEN_ONE);
         end else if ({1'b0, cnt_ff} + 3'd1 >= need) begin
            cpa_vld_in = 1'b1;
            case (need)
               u8tok_pkg::LEN_THREE:
                  cpa_raw = PW'({p0_ff[3:0], p1_ff[5:0], b[5:0]});
               u8tok_pkg::LEN_FOUR:
                  cpa_raw = PW'({p0_ff[2:0], p1_ff[5:0], p2_ff[5:0], b[5:0]});
               default: cpa_raw = u8tok_pkg::dec2(p0_ff, b);
            endcase
         end
      end else begin
         cpa_vld_in = c0 || c01 || c1;
         cpb_vld_in = c0 && c1;
         if (c0) cpa_raw = PW'(p1_ff);
         else if (c01) cpa_raw = u8tok_pkg::dec2(p1_ff, p2_ff);
         else cpa_raw = PW'(p2_ff);
      end
   end

   assign out_free = !out_vld_ff || rsp_tready;
   assign match    = chk_vld_ff && (rd_data == cp_ff);
   assign rd_en    = scan_busy_ff && (idx_ff < entries_ff) && !match;
   assign insert   = cmd.apply && learn_ff && !found_vld_ff && (entries_ff < CW'(u8tok_pkg::VOCAB_DEPTH));
   assign out_load = cmd.emit_bos || cmd.final_emit || (cmd.apply && !learn_ff);

   u8tok_ram #(.WIDTH(PW), .DEPTH(u8tok_pkg::VOCAB_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (insert),
      .wr_addr (entries_ff[AW-1:0]),
      .wr_data (cp_ff),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= 1'b0;
         learn_cfg_ff <= 1'b0;
         learn_ff <= 1'b0;
         p0_ff <= '0;
         p1_ff <= '0;
         p2_ff <= '0;
         cnt_ff <= '0;
         in_text_ff <= 1'b0;
         added_ff <= '0;
         full_ff <= 1'b0;
         entries_ff <= u8tok_pkg::FIRST_ID;
         bos_ff <= 1'b0;
         eot_ff <= 1'b0;
         cpa_vld_ff <= 1'b0;
         cpb_vld_ff <= 1'b0;
         scan_busy_ff <= 1'b0;
         chk_vld_ff <= 1'b0;
         found_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == u8tok_pkg::CSR_LOWER) lower_ff <= csr_wdata;
            else learn_cfg_ff <= csr_wdata;
         end
         if (cmd.accept) begin
            learn_ff <= learn_now;
            eot_ff <= req_tuser;
            cpa_vld_ff <= cpa_vld_in;
            cpb_vld_ff <= cpb_vld_in;
            cpa_ff <= u8tok_pkg::norm_cp(cpa_raw, lower_now);
            cpb_ff <= u8tok_pkg::norm_cp(cpb_raw, lower_now);
            if (req_tuser == u8tok_pkg::FUNC_BYTE) begin
               bos_ff <= bos_in;
               in_text_ff <= 1'b1;
               if (cnt_ff == 2'd0) begin
                  if (len_b > u8tok_pkg::LEN_ONE) begin
                     p0_ff <= b;
                     cnt_ff <= 2'd1;
                  end
               end else if (cpa_vld_in) begin
                  cnt_ff <= 2'd0;
               end else begin
                  if (cnt_ff == 2'd1) p1_ff <= b;
                  else p2_ff <= b;
                  cnt_ff <= cnt_ff + 2'd1;
               end
            end else begin
               bos_ff <= bos_in;
               in_text_ff <= 1'b0;
               p0_ff <= '0;
               p1_ff <= '0;
               p2_ff <= '0;
               cnt_ff <= '0;
            end
         end
         if (cmd.load) begin
            cp_ff <= cmd.load_sel ? cpb_ff : cpa_ff;
            idx_ff <= u8tok_pkg::FIRST_ID;
            scan_busy_ff <= 1'b1;
            chk_vld_ff <= 1'b0;
            found_vld_ff <= 1'b0;
         end else if (scan_busy_ff) begin
            chk_vld_ff <= rd_en;
            chk_addr_ff <= idx_ff[AW-1:0];
            if (rd_en) idx_ff <= idx_ff + CW'(1);
            if (match) begin
               found_ff <= chk_addr_ff;
               found_vld_ff <= 1'b1;
               scan_busy_ff <= 1'b0;
            end else if (!rd_en && !chk_vld_ff) begin
               scan_busy_ff <= 1'b0;
            end
         end
         if (insert) begin
            entries_ff <= entries_ff + CW'(1);
            if (added_ff != u8tok_pkg::ADD_MAX) added_ff <= added_ff + IW'(1);
         end else if (cmd.apply && learn_ff && !found_vld_ff) begin
            full_ff <= 1'b1;
         end
         if (cmd.final_emit) begin
            added_ff <= '0;
            full_ff <= 1'b0;
         end
         if (out_load) out_vld_ff <= 1'b1;
         else if (rsp_tready) out_vld_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_add_ff  <= '0;
         out_sum_ff  <= 1'b0;
         out_full_ff <= 1'b0;
         if (cmd.emit_bos) begin
            out_id_ff   <= u8tok_pkg::ID_BOS;
            out_last_ff <= !eot_ff && !cpa_vld_ff;
         end else if (cmd.apply) begin
            out_id_ff   <= found_vld_ff ? IW'(found_ff) : u8tok_pkg::ID_UNK;
            out_last_ff <= !eot_ff;
         end else begin
            out_last_ff <= 1'b1;
            if (learn_ff) begin
               out_id_ff   <= '0;
               out_add_ff  <= added_ff;
               out_sum_ff  <= 1'b1;
               out_full_ff <= full_ff;
            end else begin
               out_id_ff <= u8tok_pkg::ID_EOS;
            end
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(u8tok_pkg::RSP_DATA_W - 2*IW){1'b0}}, out_add_ff, out_id_ff};
   assign rsp_tuser  = {out_full_ff, out_sum_ff};
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      sts.out_free  = out_free;
      sts.scan_busy = scan_busy_ff;
      sts.bos       = bos_ff;
      sts.cpa_vld   = cpa_vld_ff;
      sts.cpb_vld   = cpb_vld_ff;
      sts.eot       = eot_ff;
   end
endmodule

// ===== design/utf8_codepoint_tokenizer.sv =====
// top level of the utf-8 code point tokenizer
// depends on u8tok_pkg, u8tok_ctrl, u8tok_dp
`timescale 1ns / 1ps
// usage:
// req channel carries one request per text byte (tuser 0) or an end of text
// marker (tuser 1); tdata holds the raw byte.
// rsp channel carries token ids: bos, one id per code point (unk if unknown)
// and eos, or in learn mode one summary at end of text; tlast marks the last
// result of a request. up to three results per request.
// csr port writes lowercase_enable (index 0) and learn_mode (index 1); the user
// must write them only while idle, which the block itself does not enforce.
// a byte that completes a code point scans the table one entry a cycle. the
// block takes one request at a time; an end of text marker that flushes two
// code points scans for each in turn through the single read port of the
// vocabulary memory.
// reset clears the pending sequence, counters, csr values and the table fill
// count; the table contents need no clearing. tready rises the cycle after reset.
// when the receiver stalls, the result register holds and the block waits
// before producing the next result; no results are dropped.
module utf8_codepoint_tokenizer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [u8tok_pkg::REQ_DATA_W-1:0]    req_tdata,   // data_byte
   input  logic                                req_tuser,   // func
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [u8tok_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // tok_id, added_count
   output logic [u8tok_pkg::RSP_USER_W-1:0]    rsp_tuser,   // is_summary, table_full
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic                                csr_wdata
);
   u8tok_pkg::cmd_type    cmd;
   u8tok_pkg::status_type sts;

   u8tok_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   u8tok_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );
endmodule

// ===== design/u8tok_checker.sv =====
// port level checks of the tokenizer and their bind to the top level
// depends on u8tok_pkg
`timescale 1ns / 1ps
module u8tok_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [u8tok_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [u8tok_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                             rsp_tlast
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_summary_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[9:0] == 10'd0 && rsp_tlast)
      else $error("bad summary result");

   a_token_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[19:10] == 10'd0 && !rsp_tuser[1])
      else $error("bad token result");
endmodule

bind utf8_codepoint_tokenizer u8tok_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/utf8_codepoint_tokenizer_tb.sv =====
// self-checking testbench of the utf-8 code point tokenizer: byte and end of text requests
// are driven on the req stream, a scoreboard class predicts and checks every rsp result
// depends on u8tok_pkg and utf8_codepoint_tokenizer
`timescale 1ns / 1ps

typedef struct packed {
   logic [9:0] id;
   logic [9:0] added;
   logic       summ;
   logic       full;
   logic       last;
} token_result_type;

class tokenizer_scoreboard;
   logic [20:0]      vocab [1024];
   int               fill;
   logic [7:0]       held [3];
   int               held_n;
   bit               in_text;
   int               added;
   bit               full_seen;
   bit               lower_en;
   bit               learn_en;
   token_result_type want [$];
   token_result_type burst [$];
   int               errors;

   function new();
      fill = 4;
      held_n = 0;
      in_text = 0;
      added = 0;
      full_seen = 0;
      lower_en = 0;
      learn_en = 0;
      errors = 0;
   endfunction

   function int lead_len(logic [7:0] b);
      if (b[7] == 1'b0) return 1;
      if (b[7:5] == 3'b110) return 2;
      if (b[7:4] == 4'b1110) return 3;
      if (b[7:3] == 5'b11110) return 4;
      return 0;
   endfunction

   function logic [20:0] join_seq(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                  logic [7:0] b3, int n);
      if (n == 1) return {13'd0, b0};
      if (n == 2) return {10'd0, b0[4:0], b1[5:0]};
      if (n == 3) return {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
   endfunction

   function void push_token(logic [9:0] id, logic [9:0] cnt, bit summ, bit full);
      token_result_type r;
      r.id = id;
      r.added = cnt;
      r.summ = summ;
      r.full = full;
      r.last = 0;
      burst.insert(burst.size(), r);
   endfunction

   function void lookup_code(logic [20:0] cp);
      int hit;
      hit = 0;
      if (cp == 21'h2018 || cp == 21'h2019) cp = 21'h27;
      if (lower_en && cp >= 21'h41 && cp <= 21'h5A) cp = cp + 21'h20;
      for (int i = 4; i < fill; i++) begin
         if (vocab[i] == cp) begin
            hit = i;
            break;
         end
      end
      if (learn_en) begin
         if (hit == 0) begin
            if (fill < 1024) begin
               vocab[fill] = cp;
               fill++;
               if (added < 1023) added++;
            end else begin
               full_seen = 1;
            end
         end
      end else begin
         push_token(hit != 0 ? 10'(hit) : u8tok_pkg::ID_UNK, 10'd0, 0, 0);
      end
   endfunction

   function void note_request(logic func, logic [7:0] b);
      int need;
      int m;
      int i;
      int n;
      logic [7:0] s [4];
      burst.delete();
      if (func == u8tok_pkg::FUNC_BYTE) begin
         if (!in_text) begin
            in_text = 1;
            if (!learn_en) push_token(u8tok_pkg::ID_BOS, 10'd0, 0, 0);
         end
         if (held_n == 0) begin
            n = lead_len(b);
            if (n == 1) lookup_code({13'd0, b});
            else if (n > 1) begin
               held[0] = b;
               held_n = 1;
            end
         end else begin
            need = lead_len(held[0]);
            if (need < 2) need = 2;
            s[0] = held[0];
            s[1] = held[1];
            s[2] = held[2];
            s[3] = 8'd0;
            s[held_n] = b;
            if (held_n + 1 >= need) begin
               lookup_code(join_seq(s[0], s[1], s[2], s[3], need));
               held_n = 0;
            end else begin
               held[held_n] = b;
               held_n++;
            end
         end
      end else begin
         m = held_n > 0 ? held_n - 1 : 0;
         if (m > 2) m = 2;
         if (!learn_en && !in_text) push_token(u8tok_pkg::ID_BOS, 10'd0, 0, 0);
         i = 0;
         while (i < m) begin
            n = lead_len(held[1 + i]);
            if (n == 0 || i + n > m) begin
               i++;
            end else begin
               lookup_code(join_seq(held[1 + i], held[2], 8'd0, 8'd0, n));
               i += n;
            end
         end
         if (learn_en) push_token(10'd0, 10'(added), 1, full_seen);
         else push_token(u8tok_pkg::ID_EOS, 10'd0, 0, 0);
         held = '{8'd0, 8'd0, 8'd0};
         held_n = 0;
         in_text = 0;
         added = 0;
         full_seen = 0;
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1;
      foreach (burst[k]) want.insert(want.size(), burst[k]);
   endfunction

   function void check_result(token_result_type got);
      token_result_type exp;
      if (want.size() == 0) begin
         $display("%0t: unexpected result expected none actual %p", $realtime, got);
         errors++;
         return;
      end
      exp = want.pop_front();
      if (got !== exp) begin
         $display("%0t: result mismatch expected %p actual %p", $realtime, exp, got);
         errors++;
      end
   endfunction
endclass

module utf8_codepoint_tokenizer_tb;

   localparam int LIMIT = 6000000;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [u8tok_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                             req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [u8tok_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [u8tok_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_we;
   logic                             csr_index;
   logic                             csr_wdata;

   tokenizer_scoreboard sb;
   int send_idle;
   int recv_stall;
   int cycles;
   int sent;

   utf8_codepoint_tokenizer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("utf8_codepoint_tokenizer regression: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready = 1'b0;
      else rsp_tready = ($urandom_range(99) >= recv_stall);
   end

   always @(posedge clock) begin
      token_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.id = rsp_tdata[9:0];
         got.added = rsp_tdata[19:10];
         got.summ = rsp_tuser[0];
         got.full = rsp_tuser[1];
         got.last = rsp_tlast;
         sb.check_result(got);
      end
   end

   task automatic send(logic func, logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = func;
      req_tdata = b;
      do @(posedge clock); while (!req_tready);
      sb.note_request(func, b);
      sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_code(int cp);
      if (cp < 'h80) begin
         send(u8tok_pkg::FUNC_BYTE, 8'(cp));
      end else if (cp < 'h800) begin
         send(u8tok_pkg::FUNC_BYTE, 8'hC0 | 8'(cp >> 6));
         send(u8tok_pkg::FUNC_BYTE, 8'h80 | 8'(cp & 'h3F));
      end else if (cp < 'h10000) begin
         send(u8tok_pkg::FUNC_BYTE, 8'hE0 | 8'(cp >> 12));
         send(u8tok_pkg::FUNC_BYTE, 8'h80 | 8'((cp >> 6) & 'h3F));
         send(u8tok_pkg::FUNC_BYTE, 8'h80 | 8'(cp & 'h3F));
      end else begin
         send(u8tok_pkg::FUNC_BYTE, 8'hF0 | 8'(cp >> 18));
         send(u8tok_pkg::FUNC_BYTE, 8'h80 | 8'((cp >> 12) & 'h3F));
         send(u8tok_pkg::FUNC_BYTE, 8'h80 | 8'((cp >> 6) & 'h3F));
         send(u8tok_pkg::FUNC_BYTE, 8'h80 | 8'(cp & 'h3F));
      end
   endtask

   // learn-mode bytes and stray lead bytes give no result, so allow a full scan
   task automatic settle();
      while (sb.want.size() != 0) @(negedge clock);
      repeat (sb.fill + 20) @(negedge clock);
   endtask

   task automatic csr_write(logic idx, logic val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == u8tok_pkg::CSR_LOWER) sb.lower_en = val;
      else sb.learn_en = val;
   endtask

   function automatic int pick_code();
      case ($urandom_range(5))
         0: return 'h41 + $urandom_range(25);
         1: return 'h61 + $urandom_range(5);
         2: return 'h80 + $urandom_range(15);
         3: return $urandom_range(1) ? 'h2018 : 'h2019;
         4: return 'h800 + $urandom_range(7);
         default: return 'h1F600 + $urandom_range(3);
      endcase
   endfunction

   task automatic random_text();
      int n;
      n = $urandom_range(5);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(9))
            0: send(u8tok_pkg::FUNC_BYTE, 8'($urandom_range(255)));
            1: send(u8tok_pkg::FUNC_BYTE, 8'hC0 | 8'($urandom_range(63)));
            default: send_code(pick_code());
         endcase
      end
      if ($urandom_range(4) == 0) begin
         send(u8tok_pkg::FUNC_BYTE, 8'hF0 | 8'($urandom_range(7)));
         repeat ($urandom_range(2)) send(u8tok_pkg::FUNC_BYTE, 8'($urandom_range(255)));
      end
      send(u8tok_pkg::FUNC_EOT, 8'($urandom_range(255)));
   endtask

   initial begin
      sb = new();
      cycles = 0;
      sent = 0;
      send_idle = 0;
      recv_stall = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // directed: empty texts, normalisation, stray bytes, truncated sequences
      csr_write(u8tok_pkg::CSR_LOWER, 1'b0);
      csr_write(u8tok_pkg::CSR_LEARN, 1'b0);
      send(u8tok_pkg::FUNC_EOT, 8'hFF);
      settle();
      csr_write(u8tok_pkg::CSR_LEARN, 1'b1);
      send(u8tok_pkg::FUNC_EOT, 8'h00);
      send_code('h41);
      send_code('h2019);
      send_code('hE9);
      send_code('h1F600);
      send(u8tok_pkg::FUNC_BYTE, 8'h00);
      send(u8tok_pkg::FUNC_EOT, 8'h00);
      settle();
      csr_write(u8tok_pkg::CSR_LEARN, 1'b0);
      csr_write(u8tok_pkg::CSR_LOWER, 1'b1);
      send_code('h41);
      send_code('h2018);
      send(u8tok_pkg::FUNC_BYTE, 8'hFF);
      send(u8tok_pkg::FUNC_BYTE, 8'h80);
      send_code('h1F600);
      send(u8tok_pkg::FUNC_BYTE, 8'hF0);
      send(u8tok_pkg::FUNC_BYTE, 8'h9F);
      send(u8tok_pkg::FUNC_BYTE, 8'h98);
      send(u8tok_pkg::FUNC_EOT, 8'h00);
      send(u8tok_pkg::FUNC_BYTE, 8'hE2);
      send(u8tok_pkg::FUNC_BYTE, 8'h41);
      send(u8tok_pkg::FUNC_EOT, 8'h00);
      settle();
      // mode switch mid text: the text started in learn mode, so no bos at all
      csr_write(u8tok_pkg::CSR_LEARN, 1'b1);
      send_code('h5A);
      settle();
      csr_write(u8tok_pkg::CSR_LEARN, 1'b0);
      send_code('h7A);
      send(u8tok_pkg::FUNC_BYTE, 8'hF4);
      send(u8tok_pkg::FUNC_BYTE, 8'h41);
      send(u8tok_pkg::FUNC_BYTE, 8'h42);
      send(u8tok_pkg::FUNC_EOT, 8'h00);
      settle();

      // random texts under three idling profiles
      sent = 0;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 24 : (ph == 1) ? 81 : 0;
         recv_stall = (ph == 0) ? 81 : (ph == 1) ? 24 : 0;
         while (sent < 60 * (ph + 1)) begin
            if ($urandom_range(3) == 0) begin
               settle();
               csr_write(u8tok_pkg::CSR_LOWER, 1'($urandom_range(1)));
               csr_write(u8tok_pkg::CSR_LEARN, 1'($urandom_range(1)));
            end
            random_text();
         end
      end

      settle();
      if (sb.want.size() != 0) begin
         $display("%0t: %0d results missing", $realtime, sb.want.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("utf8_codepoint_tokenizer regression: pass");
      end else begin
         $display("utf8_codepoint_tokenizer regression: fail");
      end
      $finish;
   end
endmodule

// ===== files.f =====
design/u8tok_pkg.sv
design/u8tok_ram.sv
design/u8tok_ctrl.sv
design/u8tok_dp.sv
design/utf8_codepoint_tokenizer.sv
design/u8tok_checker.sv
tb/utf8_codepoint_tokenizer_tb.sv
